// ===== hdl/crc16_framed_command_deframer_assert.svh =====
// concurrent check macros, empty when synthesised
`ifndef CRC16_FRAMED_COMMAND_DEFRAMER_ASSERT_SVH
`define CRC16_FRAMED_COMMAND_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("invariant check failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/crc16fd_pkg.sv =====
`timescale 1ns / 1ps

package crc16fd_pkg;

   localparam int BYTE_W       = 8;
   localparam int CRC_W        = 16;
   localparam int MAX_PAYLOAD  = 64;
   localparam int LEN_W        = 7;
   localparam int POS_W        = 6;
   localparam int MAX_LEN_CODE = MAX_PAYLOAD + 1;
   localparam int CRC_STEPS    = 8;
   localparam int STEP_W       = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hA5;
   localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h5A;
   localparam logic [CRC_W-1:0]  POLY_RESET = 16'h1021;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAD = 2'd0,
      CSR_TAIL = 2'd1,
      CSR_POLY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              clear;
      logic              load;
      logic              from_zero;
      logic [BYTE_W-1:0] data;
   } crc_cmd_type;

   typedef struct packed {
      logic              we;
      logic [POS_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic              start;
      logic [BYTE_W-1:0] frame_type;
      logic [LEN_W-1:0]  data_len;
   } emit_cmd_type;

endpackage

// ===== hdl/crc16fd_channels.sv =====
`timescale 1ns / 1ps

interface crc16fd_req_if
   import crc16fd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc16fd_rsp_if
   import crc16fd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_type;
   logic [LEN_W-1:0]  payload_length;
   logic              has_data;
   logic [BYTE_W-1:0] payload_byte;
   logic [POS_W-1:0]  byte_position;
   logic              last_of_frame;

   modport source (
      output valid, output frame_type, output payload_length, output has_data,
      output payload_byte, output byte_position, output last_of_frame,
      input ready
   );
   modport sink (
      input valid, input frame_type, input payload_length, input has_data,
      input payload_byte, input byte_position, input last_of_frame,
      output ready
   );
endinterface

// ===== hdl/crc16fd_crc_serial.sv =====
`timescale 1ns / 1ps
`include "crc16_framed_command_deframer_assert.svh"

module crc16fd_crc_serial
   import crc16fd_pkg::*;
   (
   input  logic             clock,
   input  logic             reset,
   input  crc_cmd_type      cmd,
   input  logic [CRC_W-1:0] polynomial,
   output logic [CRC_W-1:0] crc,
   output logic             busy
   );

   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [CRC_W-1:0]  shifted;

   assign shifted = {crc_ff[CRC_W-2:0], 1'b0};

   always_comb begin
      crc_in   = crc_ff;
      steps_in = steps_ff;
      priority if (cmd.clear) begin
         crc_in   = '0;
         steps_in = '0;
      end else if (cmd.load) begin
         // byte goes in at the top, then one bit per cycle
         crc_in   = (cmd.from_zero ? '0 : crc_ff) ^ {cmd.data, {(CRC_W-BYTE_W){1'b0}}};
         steps_in = STEP_W'(CRC_STEPS);
      end else if (steps_ff != '0) begin
         crc_in   = crc_ff[CRC_W-1] ? (shifted ^ polynomial) : shifted;
         steps_in = steps_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         steps_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         steps_ff <= steps_in;
      end
   end

   assign crc  = crc_ff;
   assign busy = (steps_ff != '0);

   `ASSERT_IMPLIES(a_no_load_while_busy, clock, reset, cmd.load, !busy)
   `ASSERT_NEXT(a_busy_after_load, clock, reset, cmd.load && !cmd.clear, busy)
   `ASSERT_ALWAYS(a_step_count_range, clock, reset, steps_ff <= STEP_W'(CRC_STEPS))

endmodule

// ===== hdl/crc16fd_emitter.sv =====
`timescale 1ns / 1ps
`include "crc16_framed_command_deframer_assert.svh"

module crc16fd_emitter
   import crc16fd_pkg::*;
   (
   input  logic                 clock,
   input  logic                 reset,
   input  store_wr_type         wr,
   input  emit_cmd_type         cmd,
   output logic                 busy,
   crc16fd_rsp_if.source        rsp_if
   );

   typedef enum logic [1:0] {
      E_IDLE,
      E_FETCH,
      E_SEND
   } emit_state_type;

   emit_state_type    state_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [BYTE_W-1:0] type_ff;
   logic              has_data_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] store_mem [MAX_PAYLOAD];
   logic              last_beat;

   assign last_beat = !has_data_ff || (({1'b0, pos_ff} + LEN_W'(1)) == len_ff);

   always_ff @(posedge clock) begin
      if (wr.we) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (state_ff == E_FETCH) begin
         rd_data_ff <= store_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         unique case (state_ff)
            E_IDLE: begin
               if (cmd.start) begin
                  type_ff     <= cmd.frame_type;
                  len_ff      <= cmd.data_len;
                  pos_ff      <= '0;
                  has_data_ff <= (cmd.data_len != '0);
                  // type-only frame needs no store read
                  state_ff    <= (cmd.data_len == '0) ? E_SEND : E_FETCH;
               end
            end
            E_FETCH: begin
               state_ff <= E_SEND;
            end
            E_SEND: begin
               if (rsp_if.ready) begin
                  if (last_beat) begin
                     state_ff <= E_IDLE;
                  end else begin
                     pos_ff   <= pos_ff + POS_W'(1);
                     state_ff <= E_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign busy                  = (state_ff != E_IDLE);
   assign rsp_if.valid          = (state_ff == E_SEND);
   assign rsp_if.frame_type     = type_ff;
   assign rsp_if.payload_length = has_data_ff ? len_ff : '0;
   assign rsp_if.has_data       = has_data_ff;
   assign rsp_if.payload_byte   = has_data_ff ? rd_data_ff : '0;
   assign rsp_if.byte_position  = has_data_ff ? pos_ff : '0;
   assign rsp_if.last_of_frame  = last_beat;

   `ASSERT_IMPLIES(a_start_only_idle, clock, reset, cmd.start, !busy)
   `ASSERT_IMPLIES(a_type_only_is_last, clock, reset, rsp_if.valid && !rsp_if.has_data, rsp_if.last_of_frame)
   `ASSERT_NEXT(a_quiet_after_last, clock, reset, rsp_if.valid && rsp_if.ready && rsp_if.last_of_frame, !rsp_if.valid)

endmodule

// ===== hdl/crc16_framed_command_deframer.sv =====
`timescale 1ns / 1ps
// Frame parser for a byte stream: HEAD, LEN, TYPE, DATA..., CRC high, CRC low, TAIL.
// req_if carries one received byte per beat; rsp_if carries one result per data
// byte of a good frame, or a single result with has_data low for a type-only frame.
// LEN counts TYPE plus DATA, 1 to 65; anything else drops back to hunting for HEAD.
// The CRC-16 (seed zero, MSB first, polynomial from csr) covers TYPE and DATA.
// csr_we/csr_index/csr_wdata write head byte (0), tail byte (1) and polynomial (2);
// write only while the block is idle.
// After each TYPE or DATA byte is accepted, the bit-serial CRC unit shifts it in before
// the next byte is taken; other bytes need no shifting. req_if.ready is low while the
// CRC unit shifts or a frame is being emitted.
// After a good TAIL the emitter steps through FETCH (a registered read of the payload
// store) and then SEND for each data result; a type-only frame goes straight to SEND.
// A stalled rsp_if simply holds the current result; no input is taken meanwhile.
// Reset (synchronous) restores the register defaults and the hunting state; no
// clearing pass, the block is ready on the cycle after reset.
module crc16_framed_command_deframer
   import crc16fd_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   crc16fd_req_if.sink           req_if,
   crc16fd_rsp_if.source         rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
   );

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_TYPE,
      PH_DATA,
      PH_CRCH,
      PH_CRCL,
      PH_TAIL
   } phase_type;

   phase_type         phase_ff;
   logic [BYTE_W-1:0] head_ff, tail_ff;
   logic [CRC_W-1:0]  poly_ff;
   logic [LEN_W-1:0]  frame_len_ff;
   logic [LEN_W-1:0]  rcvd_ff;
   logic [BYTE_W-1:0] type_ff;
   logic [CRC_W-1:0]  crc_rx_ff;

   logic              accept;
   logic [BYTE_W-1:0] rx;
   logic              crc_busy, emit_busy;
   logic [CRC_W-1:0]  crc_value;
   logic [LEN_W:0]    rcvd_plus2;
   crc_cmd_type       crc_cmd;
   store_wr_type      store_wr;
   emit_cmd_type      emit_cmd;

   assign rx            = req_if.rx_byte;
   assign req_if.ready  = !crc_busy && !emit_busy;
   assign accept        = req_if.valid && req_if.ready;
   assign rcvd_plus2    = {1'b0, rcvd_ff} + (LEN_W+1)'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
         tail_ff <= TAIL_RESET;
         poly_ff <= POLY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEAD: head_ff <= csr_wdata[BYTE_W-1:0];
            CSR_TAIL: tail_ff <= csr_wdata[BYTE_W-1:0];
            CSR_POLY: poly_ff <= csr_wdata[CRC_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      crc_cmd   = '0;
      store_wr  = '0;
      emit_cmd  = '0;
      crc_cmd.data        = rx;
      store_wr.addr       = rcvd_ff[POS_W-1:0];
      store_wr.data       = rx;
      emit_cmd.frame_type = type_ff;
      emit_cmd.data_len   = frame_len_ff - LEN_W'(1);
      if (accept) begin
         unique case (phase_ff)
            PH_LEN:  crc_cmd.clear = 1'b1;
            PH_TYPE: begin
               crc_cmd.load      = 1'b1;
               crc_cmd.from_zero = 1'b1;
            end
            PH_DATA: begin
               crc_cmd.load = 1'b1;
               store_wr.we  = 1'b1;
            end
            PH_TAIL: emit_cmd.start = (rx == tail_ff) && (crc_value == crc_rx_ff);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         frame_len_ff <= '0;
         rcvd_ff      <= '0;
         type_ff      <= '0;
         crc_rx_ff    <= '0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx == head_ff) begin
                  phase_ff <= PH_LEN;
               end
            end
            PH_LEN: begin
               rcvd_ff <= '0;
               if (rx == '0 || rx > BYTE_W'(MAX_LEN_CODE)) begin
                  frame_len_ff <= '0;
                  phase_ff     <= PH_HUNT;
               end else begin
                  frame_len_ff <= rx[LEN_W-1:0];
                  phase_ff     <= PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_ff  <= rx;
               rcvd_ff  <= '0;
               phase_ff <= (frame_len_ff <= LEN_W'(1)) ? PH_CRCH : PH_DATA;
            end
            PH_DATA: begin
               rcvd_ff <= rcvd_ff + LEN_W'(1);
               // this byte was the last of the data field
               if (rcvd_plus2 >= {1'b0, frame_len_ff}) begin
                  phase_ff <= PH_CRCH;
               end
            end
            PH_CRCH: begin
               crc_rx_ff <= {rx, {BYTE_W{1'b0}}};
               phase_ff  <= PH_CRCL;
            end
            PH_CRCL: begin
               crc_rx_ff <= {crc_rx_ff[CRC_W-1:BYTE_W], rx};
               phase_ff  <= PH_TAIL;
            end
            PH_TAIL: begin
               phase_ff <= PH_HUNT;
            end
            default: begin
               phase_ff <= PH_HUNT;
            end
         endcase
      end
   end

   crc16fd_crc_serial u_crc (
      .clock      (clock),
      .reset      (reset),
      .cmd        (crc_cmd),
      .polynomial (poly_ff),
      .crc        (crc_value),
      .busy       (crc_busy)
   );

   crc16fd_emitter u_emit (
      .clock  (clock),
      .reset  (reset),
      .wr     (store_wr),
      .cmd    (emit_cmd),
      .busy   (emit_busy),
      .rsp_if (rsp_if)
   );

endmodule

// ===== tb/sv/tb_crc16_framed_command_deframer.sv =====
`timescale 1ns / 1ps

module tb_crc16_framed_command_deframer;
   import crc16fd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASE_BYTES   = 16;
   localparam int NUM_PHASES    = 8;
   localparam int PRINT_LIMIT   = 40;

   typedef enum logic [2:0] {
      P_HUNT, P_LEN, P_TYPE, P_DATA, P_CRC_HI, P_CRC_LO, P_TAIL
   } parse_phase_type;

   typedef enum {FLAW_NONE, FLAW_CRC, FLAW_TAIL} frame_flaw_type;

   typedef logic [BYTE_W-1:0] byte_q_type[$];

   typedef struct {
      logic [BYTE_W-1:0] frame_type;
      logic [LEN_W-1:0]  payload_length;
      logic              has_data;
      logic [BYTE_W-1:0] payload_byte;
      logic [POS_W-1:0]  byte_position;
      logic              last_of_frame;
   } frame_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   crc16fd_req_if req_ch ();
   crc16fd_rsp_if rsp_ch ();

   crc16_framed_command_deframer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies, shared by the frame builder and the parser model
   logic [BYTE_W-1:0] head_cfg = HEAD_RESET;
   logic [BYTE_W-1:0] tail_cfg = TAIL_RESET;
   logic [CRC_W-1:0]  poly_cfg = POLY_RESET;

   // parser model state
   parse_phase_type   parse_phase = P_HUNT;
   int                frame_len   = 0;
   int                seen_count  = 0;
   logic [BYTE_W-1:0] type_held   = '0;
   logic [CRC_W-1:0]  crc_acc     = '0;
   logic [CRC_W-1:0]  crc_got     = '0;
   logic [BYTE_W-1:0] held_data [MAX_PAYLOAD];

   frame_beat_type expected_beats[$];
   byte_q_type     tx_bytes;
   int          queued_total = 0;
   int          bytes_taken  = 0;
   int          quiet_cycles = 0;
   int          error_count  = 0;
   int          gap_pct      = 0;
   int          stall_pct    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data_in,
                                                   input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] crc;
      crc = crc_in ^ {data_in, 8'h00};
      for (int k = 0; k < 8; k++) begin
         crc = crc[CRC_W-1] ? ((crc << 1) ^ poly) : (crc << 1);
      end
      return crc;
   endfunction

   // advance the parser model by one byte, queueing any frame results
   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      frame_beat_type beat;
      int          data_len;
      case (parse_phase)
         P_HUNT: begin
            if (b == head_cfg) parse_phase = P_LEN;
         end
         P_LEN: begin
            if (b == 0 || b > MAX_LEN_CODE) begin
               frame_len   = 0;
               parse_phase = P_HUNT;
            end else begin
               frame_len   = b;
               parse_phase = P_TYPE;
            end
            seen_count = 0;
            crc_acc    = '0;
         end
         P_TYPE: begin
            type_held   = b;
            crc_acc     = crc16_step('0, b, poly_cfg);
            seen_count  = 0;
            parse_phase = (frame_len <= 1) ? P_CRC_HI : P_DATA;
         end
         P_DATA: begin
            if (seen_count < MAX_PAYLOAD) held_data[seen_count] = b;
            crc_acc = crc16_step(crc_acc, b, poly_cfg);
            if (seen_count < 127) seen_count++;
            if (seen_count + 1 >= frame_len) parse_phase = P_CRC_HI;
         end
         P_CRC_HI: begin
            crc_got     = {b, 8'h00};
            parse_phase = P_CRC_LO;
         end
         P_CRC_LO: begin
            crc_got[7:0] = b;
            parse_phase  = P_TAIL;
         end
         P_TAIL: begin
            if (b == tail_cfg && crc_acc == crc_got) begin
               data_len = (frame_len > 0) ? frame_len - 1 : 0;
               if (data_len > MAX_PAYLOAD) data_len = MAX_PAYLOAD;
               beat.frame_type = type_held;
               if (data_len == 0) begin
                  beat.payload_length = '0;
                  beat.has_data       = 1'b0;
                  beat.payload_byte   = '0;
                  beat.byte_position  = '0;
                  beat.last_of_frame  = 1'b1;
                  expected_beats.push_back(beat);
               end else begin
                  for (int i = 0; i < data_len; i++) begin
                     beat.payload_length = LEN_W'(data_len);
                     beat.has_data       = 1'b1;
                     beat.payload_byte   = held_data[i];
                     beat.byte_position  = POS_W'(i);
                     beat.last_of_frame  = (i + 1 == data_len);
                     expected_beats.push_back(beat);
                  end
               end
            end
            parse_phase = P_HUNT;
         end
         default: parse_phase = P_HUNT;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   task automatic check_beat();
      frame_beat_type want;
      if (expected_beats.size() == 0) begin
         report_error("result beat with nothing outstanding");
         return;
      end
      want = expected_beats.pop_front();
      check_field("frame_type", 16'(rsp_ch.frame_type), 16'(want.frame_type));
      check_field("payload_length", 16'(rsp_ch.payload_length), 16'(want.payload_length));
      check_field("has_data", 16'(rsp_ch.has_data), 16'(want.has_data));
      check_field("payload_byte", 16'(rsp_ch.payload_byte), 16'(want.payload_byte));
      check_field("byte_position", 16'(rsp_ch.byte_position), 16'(want.byte_position));
      check_field("last_of_frame", 16'(rsp_ch.last_of_frame), 16'(want.last_of_frame));
   endtask

   // byte driver, also drives random stalls on rsp_ch.ready
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!req_ch.valid || req_ch.ready) begin
            if (tx_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= tx_bytes.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor: results are checked before the byte taken on the same edge is parsed
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_beat();
         if (req_ch.valid && req_ch.ready) begin
            deframe_byte(req_ch.rx_byte);
            bytes_taken <= bytes_taken + 1;
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb_crc16_framed_command_deframer: errors");
      $finish;
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_HEAD: head_cfg = value[BYTE_W-1:0];
         CSR_TAIL: tail_cfg = value[BYTE_W-1:0];
         CSR_POLY: poly_cfg = value[CRC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_byte(input logic [BYTE_W-1:0] b);
      tx_bytes.push_back(b);
      queued_total++;
   endtask

   task automatic add_frame(input logic [BYTE_W-1:0] ftype, input byte_q_type payload,
                            input frame_flaw_type flaw);
      logic [CRC_W-1:0] crc;
      crc = crc16_step('0, ftype, poly_cfg);
      queue_byte(head_cfg);
      queue_byte(BYTE_W'(payload.size() + 1));
      queue_byte(ftype);
      foreach (payload[i]) begin
         queue_byte(payload[i]);
         crc = crc16_step(crc, payload[i], poly_cfg);
      end
      if (flaw == FLAW_CRC) crc ^= CRC_W'(1) << $urandom_range(CRC_W - 1);
      queue_byte(crc[15:8]);
      queue_byte(crc[7:0]);
      if (flaw == FLAW_TAIL) begin
         queue_byte(tail_cfg ^ BYTE_W'($urandom_range(255, 1)));
      end else begin
         queue_byte(tail_cfg);
      end
   endtask

   // sampled on the falling edge so the queues and counters have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (bytes_taken != queued_total || expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      byte_q_type     payload;
      int             start_count;
      int             pick;
      int             data_len;
      frame_flaw_type flaw;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) wait_idle();
         case (phase)
            1: begin
               write_csr(CSR_HEAD, 16'h0000);
               write_csr(CSR_TAIL, 16'h00FF);
               write_csr(CSR_POLY, 16'hFFFF);
            end
            2: begin
               write_csr(CSR_HEAD, 16'hFFFF);
               write_csr(CSR_TAIL, 16'hFF00);
               write_csr(CSR_POLY, 16'h0000);
            end
            3: begin
               write_csr(CSR_HEAD, 16'h007E);
               write_csr(CSR_TAIL, 16'h007E);
               write_csr(CSR_POLY, 16'h8005);
            end
            4: begin
               // index with no register behind it must change nothing
               write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
               write_csr(CSR_HEAD, CSR_DATA_W'(HEAD_RESET));
               write_csr(CSR_TAIL, CSR_DATA_W'(TAIL_RESET));
               write_csr(CSR_POLY, POLY_RESET);
            end
            5, 6, 7: begin
               write_csr(CSR_HEAD, CSR_DATA_W'($urandom));
               write_csr(CSR_TAIL, CSR_DATA_W'($urandom));
               write_csr(CSR_POLY, CSR_DATA_W'($urandom));
            end
            default: ;
         endcase

         @(negedge clock);
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 47; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 47; end
            default: begin gap_pct = 17; stall_pct = 17; end
         endcase

         if (phase == 0) begin
            // stray bytes while hunting, then the bad length codes
            queue_byte(8'h00);
            queue_byte(8'hFF);
            queue_byte(head_cfg);
            queue_byte(head_cfg);
            queue_byte(head_cfg);
            queue_byte(8'h00);
            queue_byte(head_cfg);
            queue_byte(8'(MAX_LEN_CODE + 1));
            payload = {};
            add_frame(8'h00, payload, FLAW_NONE);
            payload = {8'h00, 8'hFF};
            add_frame(8'hFF, payload, FLAW_NONE);
         end
         if (phase == 2 || phase == 5) begin
            payload = {};
            repeat (MAX_PAYLOAD) payload.push_back(BYTE_W'($urandom));
            add_frame(BYTE_W'($urandom), payload, FLAW_NONE);
         end

         start_count = queued_total;
         while (queued_total - start_count < PHASE_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 83) begin
               if (pick < 65) flaw = FLAW_NONE;
               else if (pick < 75) flaw = FLAW_CRC;
               else flaw = FLAW_TAIL;
               data_len = $urandom_range(99);
               if (data_len < 80) data_len = $urandom_range(6);
               else if (data_len < 97) data_len = $urandom_range(20, 7);
               else data_len = MAX_PAYLOAD;
               payload = {};
               repeat (data_len) payload.push_back(BYTE_W'($urandom));
               add_frame(BYTE_W'($urandom), payload, flaw);
            end else if (pick < 90) begin
               queue_byte(head_cfg);
               if ($urandom_range(1)) queue_byte(8'h00);
               else queue_byte(BYTE_W'($urandom_range(255, MAX_LEN_CODE + 1)));
            end else begin
               repeat ($urandom_range(4, 1)) queue_byte(BYTE_W'($urandom));
            end
         end
         payload = {};
         repeat ($urandom_range(6)) payload.push_back(BYTE_W'($urandom));
         add_frame(BYTE_W'($urandom), payload, FLAW_NONE);
      end

      wait_idle();
      if (error_count == 0) begin
         $display("tb_crc16_framed_command_deframer: clean");
      end else begin
         $display("tb_crc16_framed_command_deframer: errors");
      end
      $finish;
   end

endmodule

// ===== crc16_framed_command_deframer.f =====
+incdir+hdl
hdl/crc16fd_pkg.sv
hdl/crc16fd_channels.sv
hdl/crc16fd_crc_serial.sv
hdl/crc16fd_emitter.sv
hdl/crc16_framed_command_deframer.sv
tb/sv/tb_crc16_framed_command_deframer.sv
